/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files of the core.
// No dependencies; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MBE_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mandelbrot core: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MBE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mandelbrot core: next-cycle check failed");

`endif

/* rtl/core/mbe_pkg.sv */
// Shared types and constants of the escape-time core: register indices,
// the microcode word and the condition flags. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  localparam int unsigned PcW = 5;
  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [2:0] {
    CFG_REAL_MIN  = 3'd0,
    CFG_IMAG_MAX  = 3'd1,
    CFG_REAL_STEP = 3'd2,
    CFG_IMAG_STEP = 3'd3,
    CFG_MAX_ITER  = 3'd4,
    CFG_ESC_BOUND = 3'd5
  } cfg_idx_e;

  // 32-bit multiplier operand sources
  typedef enum logic [3:0] {
    SRC_MR_LO,
    SRC_MR_HI,
    SRC_MI_LO,
    SRC_MI_HI,
    SRC_COL,
    SRC_ROW,
    SRC_RS_LO,
    SRC_RS_HI,
    SRC_IS_LO,
    SRC_IS_HI
  } src_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } sh_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SET_CR,
    OP_SET_CI,
    OP_MAG,
    OP_SAVE_SR,
    OP_SAVE_SI,
    OP_SUB,
    OP_NEG,
    OP_UPD_R,
    OP_UPD_I,
    OP_FIN,
    OP_FIN_ESC
  } op_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_LIMIT,
    JMP_ESCAPE
  } jmp_e;

  typedef struct packed {
    src_e a_sel;
    src_e b_sel;
    acc_e acc;
    sh_e  sh;
    op_e  op;
    jmp_e jmp;
    pc_t  target;
  } ucode_t;

  typedef struct packed {
    logic limit;
    logic escape;
  } cond_t;

  localparam ucode_t UcodeNop = '{
    a_sel:  SRC_MR_LO,
    b_sel:  SRC_MR_LO,
    acc:    ACC_HOLD,
    sh:     SH_0,
    op:     OP_NONE,
    jmp:    JMP_NONE,
    target: '0
  };

endpackage

`default_nettype wire

/* rtl/core/mbe_urom.sv */
// Microcode store of the escape-time core: one control word per step.
// Depends on mbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbe_urom import mbe_pkg::*; (
  input  pc_t    pc_i,
  output ucode_t word_o
);

  localparam pc_t LoopPc   = 5'd7;
  localparam pc_t FinPc    = 5'd24;
  localparam pc_t FinEscPc = 5'd25;

  function automatic ucode_t uw(src_e a, src_e b, acc_e c, sh_e s, op_e o,
                                jmp_e j, pc_t t);
    ucode_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc    = c;
    w.sh     = s;
    w.op     = o;
    w.jmp    = j;
    w.target = t;
    return w;
  endfunction

  // Each word issues one product; words that load or add fold in the product of the word before.
  always_comb begin
    unique case (pc_i)
      // c = corner + index * step for the real part, corner - index * step for the imaginary part
      5'd0:  word_o = uw(SRC_COL,   SRC_RS_LO, ACC_HOLD, SH_0,  OP_NONE,    JMP_NONE, '0);
      5'd1:  word_o = uw(SRC_COL,   SRC_RS_HI, ACC_LOAD, SH_0,  OP_NONE,    JMP_NONE, '0);
      5'd2:  word_o = uw(SRC_COL,   SRC_RS_HI, ACC_ADD,  SH_32, OP_NONE,    JMP_NONE, '0);
      5'd3:  word_o = uw(SRC_ROW,   SRC_IS_LO, ACC_HOLD, SH_0,  OP_SET_CR,  JMP_NONE, '0);
      5'd4:  word_o = uw(SRC_ROW,   SRC_IS_HI, ACC_LOAD, SH_0,  OP_NONE,    JMP_NONE, '0);
      5'd5:  word_o = uw(SRC_ROW,   SRC_IS_HI, ACC_ADD,  SH_32, OP_NONE,    JMP_NONE, '0);
      5'd6:  word_o = uw(SRC_ROW,   SRC_IS_HI, ACC_HOLD, SH_0,  OP_SET_CI,  JMP_NONE, '0);
      // iteration loop
      5'd7:  word_o = uw(SRC_MR_LO, SRC_MR_LO, ACC_HOLD, SH_0,  OP_MAG,     JMP_LIMIT, FinPc);
      5'd8:  word_o = uw(SRC_MR_LO, SRC_MR_LO, ACC_HOLD, SH_0,  OP_NONE,    JMP_NONE, '0);
      5'd9:  word_o = uw(SRC_MR_LO, SRC_MR_HI, ACC_LOAD, SH_0,  OP_NONE,    JMP_NONE, '0);
      5'd10: word_o = uw(SRC_MR_HI, SRC_MR_LO, ACC_ADD,  SH_32, OP_NONE,    JMP_NONE, '0);
      5'd11: word_o = uw(SRC_MR_HI, SRC_MR_HI, ACC_ADD,  SH_32, OP_NONE,    JMP_NONE, '0);
      5'd12: word_o = uw(SRC_MI_LO, SRC_MI_LO, ACC_ADD,  SH_64, OP_NONE,    JMP_NONE, '0);
      5'd13: word_o = uw(SRC_MI_LO, SRC_MI_HI, ACC_LOAD, SH_0,  OP_SAVE_SR, JMP_NONE, '0);
      5'd14: word_o = uw(SRC_MI_HI, SRC_MI_LO, ACC_ADD,  SH_32, OP_NONE,    JMP_NONE, '0);
      5'd15: word_o = uw(SRC_MI_HI, SRC_MI_HI, ACC_ADD,  SH_32, OP_NONE,    JMP_NONE, '0);
      5'd16: word_o = uw(SRC_MR_LO, SRC_MI_LO, ACC_ADD,  SH_64, OP_NONE,    JMP_NONE, '0);
      5'd17: word_o = uw(SRC_MR_LO, SRC_MI_HI, ACC_LOAD, SH_0,  OP_SAVE_SI, JMP_NONE, '0);
      5'd18: word_o = uw(SRC_MR_HI, SRC_MI_LO, ACC_ADD,  SH_32, OP_NONE,    JMP_ESCAPE, FinEscPc);
      5'd19: word_o = uw(SRC_MR_HI, SRC_MI_HI, ACC_ADD,  SH_32, OP_NONE,    JMP_NONE, '0);
      5'd20: word_o = uw(SRC_MR_HI, SRC_MI_HI, ACC_ADD,  SH_64, OP_SUB,     JMP_NONE, '0);
      5'd21: word_o = uw(SRC_MR_LO, SRC_MR_LO, ACC_HOLD, SH_0,  OP_NEG,     JMP_NONE, '0);
      5'd22: word_o = uw(SRC_MR_LO, SRC_MR_LO, ACC_HOLD, SH_0,  OP_UPD_R,   JMP_NONE, '0);
      5'd23: word_o = uw(SRC_MR_LO, SRC_MR_LO, ACC_HOLD, SH_0,  OP_UPD_I,   JMP_ALWAYS, LoopPc);
      // result
      5'd24: word_o = uw(SRC_MR_LO, SRC_MR_LO, ACC_HOLD, SH_0,  OP_FIN,     JMP_NONE, '0);
      5'd25: word_o = uw(SRC_MR_LO, SRC_MR_LO, ACC_HOLD, SH_0,  OP_FIN_ESC, JMP_NONE, '0);
      default: word_o = UcodeNop;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mbe_seq.sv */
// Step counter of the escape-time core: fetch, conditional jump, busy flag.
// Depends on mbe_pkg; the control words come from mbe_urom.
`timescale 1ns / 1ps
`default_nettype none

module mbe_seq import mbe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  ucode_t word_i,
  input  cond_t  cond_i,
  output pc_t    pc_o,
  output ucode_t ctl_o,
  output logic   busy_o
);

  pc_t  pc_q, pc_d;
  logic busy_q, busy_d;
  logic taken;
  logic fin;

  always_comb begin
    case (word_i.jmp)
      JMP_ALWAYS: taken = 1'b1;
      JMP_LIMIT:  taken = cond_i.limit;
      JMP_ESCAPE: taken = cond_i.escape;
      default:    taken = 1'b0;
    endcase
  end

  assign fin = busy_q && (word_i.op inside {OP_FIN, OP_FIN_ESC});

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      pc_d = taken ? word_i.target : pc_t'(pc_q + 1'b1);
      if (fin) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  // idle steps must not touch the datapath
  assign ctl_o  = busy_q ? word_i : UcodeNop;
  assign pc_o   = pc_q;
  assign busy_o = busy_q;

endmodule

`default_nettype wire

/* rtl/core/mbe_dpath.sv */
// Datapath of the escape-time core: one 32x32 multiplier, 128-bit
// accumulator, shared saturating adder and the coordinate registers.
// Depends on mbe_pkg; driven by the control word from mbe_seq.
`timescale 1ns / 1ps
`default_nettype none

module mbe_dpath import mbe_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 56
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  input  logic [63:0] real_min_i,
  input  logic [63:0] imag_max_i,
  input  logic [62:0] real_step_i,
  input  logic [62:0] imag_step_i,
  input  logic [12:0] max_iter_i,
  input  logic [6:0]  escape_bound_i,
  input  ucode_t      ctl_i,
  output cond_t       cond_o,
  output logic        done_o,
  output logic [12:0] iter_count_o,
  output logic        escaped_o
);

  localparam int unsigned BoundSh = 2 * COORD_FRAC_BITS;

  function automatic logic [63:0] sat64(logic [127:0] v);
    if ((&v[127:63]) || !(|v[127:63])) begin
      return v[63:0];
    end
    return v[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic [31:0] pick(src_e s, logic [63:0] mr, logic [63:0] mi,
                                       logic [11:0] col, logic [11:0] row,
                                       logic [62:0] rs, logic [62:0] is);
    logic [31:0] r;
    case (s)
      SRC_MR_LO: r = mr[31:0];
      SRC_MR_HI: r = mr[63:32];
      SRC_MI_LO: r = mi[31:0];
      SRC_MI_HI: r = mi[63:32];
      SRC_COL:   r = {20'b0, col};
      SRC_ROW:   r = {20'b0, row};
      SRC_RS_LO: r = rs[31:0];
      SRC_RS_HI: r = {1'b0, rs[62:32]};
      SRC_IS_LO: r = is[31:0];
      SRC_IS_HI: r = {1'b0, is[62:32]};
      default:   r = '0;
    endcase
    return r;
  endfunction

  logic [11:0]  col_q, row_q;
  logic [63:0]  cr_q, cr_d, ci_q, ci_d, zr_q, zr_d, zi_q, zi_d;
  logic [63:0]  mr_q, mr_d, mi_q, mi_d;
  logic         sgn_q, sgn_d;
  logic [63:0]  prod_q;
  logic [127:0] acc_q, acc_d, sr_q, sr_d, si_q, si_d;
  logic [12:0]  iter_q, iter_d;
  logic         done_q, done_d, esc_q, esc_d;
  logic [12:0]  cnt_q, cnt_d;

  logic [31:0]  op_a, op_b;
  logic [127:0] prod_sh;
  logic [127:0] add_a, add_b, add_sum;
  logic         add_cin;
  logic [63:0]  add_sat;
  logic [127:0] mag_sum, bound;
  logic [127:0] cross2;

  assign op_a = pick(ctl_i.a_sel, mr_q, mi_q, col_q, row_q, real_step_i, imag_step_i);
  assign op_b = pick(ctl_i.b_sel, mr_q, mi_q, col_q, row_q, real_step_i, imag_step_i);

  always_comb begin
    case (ctl_i.sh)
      SH_0:    prod_sh = {64'b0, prod_q};
      SH_32:   prod_sh = {32'b0, prod_q, 32'b0};
      SH_64:   prod_sh = {prod_q, 64'b0};
      default: prod_sh = '0;
    endcase
  end

  // doubled cross product, wrapping at 128 bits
  assign cross2 = {acc_q[126:0], 1'b0};

  // shared adder for coordinate forming, difference, negation and updates
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (ctl_i.op)
      OP_SET_CR: begin
        add_a = {{64{real_min_i[63]}}, real_min_i};
        add_b = acc_q;
      end
      OP_SET_CI: begin
        add_a   = {{64{imag_max_i[63]}}, imag_max_i};
        add_b   = ~acc_q;
        add_cin = 1'b1;
      end
      OP_SUB: begin
        add_a   = sr_q;
        add_b   = ~si_q;
        add_cin = 1'b1;
      end
      OP_NEG: begin
        add_b   = sgn_q ? ~acc_q : acc_q;
        add_cin = sgn_q;
      end
      OP_UPD_R: begin
        add_a = 128'($signed(sr_q) >>> COORD_FRAC_BITS);
        add_b = {{64{cr_q[63]}}, cr_q};
      end
      OP_UPD_I: begin
        add_a = 128'($signed(cross2) >>> COORD_FRAC_BITS);
        add_b = {{64{ci_q[63]}}, ci_q};
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b + {127'b0, add_cin};
  assign add_sat = sat64(add_sum);

  // exact escape test on |z|^2 against bound << 2F
  assign mag_sum       = sr_q + si_q;
  assign bound         = {121'b0, escape_bound_i} << BoundSh;
  assign cond_o.escape = mag_sum > bound;
  assign cond_o.limit  = iter_q >= max_iter_i;

  always_comb begin
    cr_d   = cr_q;
    ci_d   = ci_q;
    zr_d   = zr_q;
    zi_d   = zi_q;
    mr_d   = mr_q;
    mi_d   = mi_q;
    sgn_d  = sgn_q;
    sr_d   = sr_q;
    si_d   = si_q;
    iter_d = iter_q;
    done_d = 1'b0;
    esc_d  = esc_q;
    cnt_d  = cnt_q;

    case (ctl_i.acc)
      ACC_LOAD: acc_d = prod_sh;
      ACC_ADD:  acc_d = acc_q + prod_sh;
      default:  acc_d = acc_q;
    endcase

    case (ctl_i.op)
      OP_SET_CR: begin
        cr_d = add_sat;
        zr_d = add_sat;
      end
      OP_SET_CI: begin
        ci_d = add_sat;
        zi_d = add_sat;
      end
      OP_MAG: begin
        mr_d  = zr_q[63] ? (~zr_q + 64'd1) : zr_q;
        mi_d  = zi_q[63] ? (~zi_q + 64'd1) : zi_q;
        sgn_d = zr_q[63] ^ zi_q[63];
      end
      OP_SAVE_SR: sr_d = acc_q;
      OP_SAVE_SI: si_d = acc_q;
      OP_SUB:     sr_d = add_sum;
      OP_NEG:     acc_d = add_sum;
      OP_UPD_R: begin
        zr_d   = add_sat;
        iter_d = iter_q + 13'd1;
      end
      OP_UPD_I:   zi_d = add_sat;
      OP_FIN: begin
        done_d = 1'b1;
        cnt_d  = iter_q;
        esc_d  = 1'b0;
      end
      OP_FIN_ESC: begin
        done_d = 1'b1;
        cnt_d  = iter_q;
        esc_d  = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase

    if (start_i) begin
      iter_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    prod_q <= {32'b0, op_a} * {32'b0, op_b};
    acc_q  <= acc_d;
    cr_q   <= cr_d;
    ci_q   <= ci_d;
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    mr_q   <= mr_d;
    mi_q   <= mi_d;
    sgn_q  <= sgn_d;
    sr_q   <= sr_d;
    si_q   <= si_d;
    iter_q <= iter_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      esc_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= done_d;
      esc_q  <= esc_d;
      cnt_q  <= cnt_d;
    end
  end

  assign done_o       = done_q;
  assign iter_count_o = cnt_q;
  assign escaped_o    = esc_q;

endmodule

`default_nettype wire

/* rtl/core/mandelbrot_escape_time.sv */
// Escape-time core: config registers, index clamp, microcode sequencer, datapath.
// Each iteration runs through the loop words on the single 32x32 multiplier (12 partial products).
// A pixel ends at the iteration limit or when the point escapes. One pixel at a time:
// busy_o falls as done_o shows, and start_i may be taken in that cycle.
// Reset (rst_ni low, async) loads register defaults and leaves the core idle.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 56,
  parameter int unsigned MAX_DIM         = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  output logic        done_o,
  output logic [12:0] iter_count_o,
  output logic        escaped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam logic [16:0] DimLast = 17'(MAX_DIM - 1);

  logic [63:0] real_min_q, imag_max_q;
  logic [62:0] real_step_q, imag_step_q;
  logic [12:0] max_iter_q;
  logic [6:0]  escape_bound_q;

  logic        accept;
  logic [11:0] col_clamp, row_clamp;
  pc_t         pc;
  ucode_t      word, ctl;
  cond_t       cond;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_min_q     <= 64'hC000_0000_0000_0000;
      imag_max_q     <= 64'h1800_0000_0000_0000;
      real_step_q    <= '0;
      imag_step_q    <= '0;
      max_iter_q     <= 13'd100;
      escape_bound_q <= 7'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_REAL_MIN:  real_min_q     <= cfg_data_i;
        CFG_IMAG_MAX:  imag_max_q     <= cfg_data_i;
        CFG_REAL_STEP: real_step_q    <= cfg_data_i[62:0];
        CFG_IMAG_STEP: imag_step_q    <= cfg_data_i[62:0];
        CFG_MAX_ITER:  max_iter_q     <= cfg_data_i[12:0];
        CFG_ESC_BOUND: escape_bound_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign accept = start_i && !busy_o;

  // clamp indices beyond the raster to its last column and row
  assign col_clamp = ({5'b0, col_i} > DimLast) ? DimLast[11:0] : col_i;
  assign row_clamp = ({5'b0, row_i} > DimLast) ? DimLast[11:0] : row_i;

  mbe_urom u_urom (
    .pc_i   (pc),
    .word_o (word)
  );

  mbe_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .word_i  (word),
    .cond_i  (cond),
    .pc_o    (pc),
    .ctl_o   (ctl),
    .busy_o  (busy_o)
  );

  mbe_dpath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (accept),
    .col_i          (col_clamp),
    .row_i          (row_clamp),
    .real_min_i     (real_min_q),
    .imag_max_i     (imag_max_q),
    .real_step_i    (real_step_q),
    .imag_step_i    (imag_step_q),
    .max_iter_i     (max_iter_q),
    .escape_bound_i (escape_bound_q),
    .ctl_i          (ctl),
    .cond_o         (cond),
    .done_o         (done_o),
    .iter_count_o   (iter_count_o),
    .escaped_o      (escaped_o)
  );

endmodule

`default_nettype wire

/* rtl/core/mbe_checker.sv */
// Port-level checks of the escape-time core, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_i,
  input logic        done_i,
  input logic [12:0] iter_count_i,
  input logic        escaped_i
);

  // a strobe ends the pixel, so the core is already free for the next beat
  `MBE_ASSERT_NOW(a_idle_at_done, clk_i, rst_ni, done_i, !busy_i)
  // one strobe per pixel, never two in a row
  `MBE_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_i, !done_i)
  // an accepted beat keeps the core busy and cannot finish at once
  `MBE_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start_i && !busy_i, busy_i && !done_i)
  // result ports move only with a strobe
  `MBE_ASSERT_NOW(a_result_hold, clk_i, rst_ni, !$stable(iter_count_i) || !$stable(escaped_i), done_i)

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_i       (busy_o),
  .done_i       (done_o),
  .iter_count_i (iter_count_o),
  .escaped_i    (escaped_o)
);

`default_nettype wire
